@@ rtl/obpc_pkg.sv @@
// Shared constants, register codes and pipeline control type for the oriented box point crop.
`timescale 1ns / 1ps

package obpc_pkg;

   // Default sizes of the point, axis and index fields
   localparam int COORD_BITS_DEF     = 20;
   localparam int AXIS_FRAC_BITS_DEF = 14;
   localparam int INDEX_BITS_DEF     = 20;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER      = 3'd0,
      CSR_AXIS_X      = 3'd1,
      CSR_AXIS_Y      = 3'd2,
      CSR_AXIS_Z      = 3'd3,
      CSR_HALF_EXTENT = 3'd4
   } csr_code_type;

   // Load enables for the stages inside one projection lane
   typedef struct packed {
      logic prod_load;
      logic dot_load;
      logic cmp_load;
   } stage_ctrl_type;

endpackage

@@ rtl/obpc_axis_lane.sv @@
// One box axis: three products, their sum and the inclusive extent check, one stage each.
`timescale 1ns / 1ps

module obpc_axis_lane #(
   parameter int COORD_BITS     = obpc_pkg::COORD_BITS_DEF,
   parameter int AXIS_FRAC_BITS = obpc_pkg::AXIS_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  obpc_pkg::stage_ctrl_type        ctrl,
   input  logic [3*(COORD_BITS+1)-1:0]     diff,
   input  logic [3*(AXIS_FRAC_BITS+2)-1:0] axis,
   input  logic [COORD_BITS-1:0]           half_extent,
   output logic                            in_box
);
   import obpc_pkg::*;

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int AXIS_BITS = AXIS_FRAC_BITS + 2;
   localparam int PROD_BITS = DIFF_BITS + AXIS_BITS;
   localparam int DOT_BITS  = PROD_BITS + 2;

   logic signed [PROD_BITS-1:0] prod_in [3];
   logic signed [PROD_BITS-1:0] prod_ff [3];
   logic signed [DOT_BITS-1:0]  dot_in;
   logic signed [DOT_BITS-1:0]  dot_ff;
   logic        [DOT_BITS-1:0]  mag;
   logic        [DOT_BITS-1:0]  lim;
   logic                        inside_in;
   logic                        inside_ff;

   // Component products, both operands signed
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         prod_in[j] = $signed(diff[j*DIFF_BITS +: DIFF_BITS])
                    * $signed(axis[j*AXIS_BITS +: AXIS_BITS]);
      end
   end

   // Dot product, grown by two bits for the three-term sum
   assign dot_in = DOT_BITS'(prod_ff[0]) + DOT_BITS'(prod_ff[1]) + DOT_BITS'(prod_ff[2]);

   // Magnitude against half extent scaled to the axis fraction
   assign mag = dot_ff[DOT_BITS-1] ? DOT_BITS'(-dot_ff) : DOT_BITS'(dot_ff);
   assign lim = DOT_BITS'({half_extent, {AXIS_FRAC_BITS{1'b0}}});
   assign inside_in = (mag <= lim);

   always_ff @(posedge clock) begin
      if (ctrl.prod_load) begin
         prod_ff <= prod_in;
      end
      if (ctrl.dot_load) begin
         dot_ff <= dot_in;
      end
      if (ctrl.cmp_load) begin
         inside_ff <= inside_in;
      end
   end

   assign in_box = inside_ff;

endmodule

@@ rtl/oriented_box_point_crop.sv @@
// Top level of the oriented box point crop: registers, centre subtract and pipeline control.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   point_x, point_y, point_z, point_index, last_point
//   rsp      out        rsp_valid / rsp_ready   result_index, inside_res, result_last
//   csr      in         csr_write_en            csr_index, csr_wdata
//
// One item per cycle while rsp_ready is high; each item passes through the four register stages
// of the pipeline (centre subtract, products, dot sums, extent compare).
// Synchronous active-high reset empties the pipeline and loads identity axes, zero centre
// and zero half extents. A stage holds while the one after it is full and stalled, so
// rsp_ready low backs up through the stages to req_ready without losing an item.
`timescale 1ns / 1ps

module oriented_box_point_crop #(
   parameter int COORD_BITS     = obpc_pkg::COORD_BITS_DEF,
   parameter int AXIS_FRAC_BITS = obpc_pkg::AXIS_FRAC_BITS_DEF,
   parameter int INDEX_BITS     = obpc_pkg::INDEX_BITS_DEF,
   localparam int CSR_DATA_BITS = (3*COORD_BITS > 3*(AXIS_FRAC_BITS+2))
                                  ? 3*COORD_BITS : 3*(AXIS_FRAC_BITS+2)
) (
   input  logic                                clock,
   input  logic                                reset,
   // point input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_BITS-1:0]        req_point_x,
   input  logic signed [COORD_BITS-1:0]        req_point_y,
   input  logic signed [COORD_BITS-1:0]        req_point_z,
   input  logic        [INDEX_BITS-1:0]        req_point_index,
   input  logic                                req_last_point,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [INDEX_BITS-1:0]        rsp_result_index,
   output logic                                rsp_inside_res,
   output logic                                rsp_result_last,
   // configuration writes
   input  logic                                csr_write_en,
   input  logic [obpc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]            csr_wdata
);
   import obpc_pkg::*;

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int AXIS_BITS = AXIS_FRAC_BITS + 2;
   localparam int CTR_BITS  = 3 * COORD_BITS;
   localparam int AXV_BITS  = 3 * AXIS_BITS;

   localparam logic [AXIS_BITS-1:0] AXIS_ONE = AXIS_BITS'(1) << AXIS_FRAC_BITS;
   localparam logic [AXIS_BITS-1:0] AXIS_NIL = '0;

   // Configuration registers
   logic [CTR_BITS-1:0] center_ff;
   logic [AXV_BITS-1:0] axis_x_ff;
   logic [AXV_BITS-1:0] axis_y_ff;
   logic [AXV_BITS-1:0] axis_z_ff;
   logic [CTR_BITS-1:0] half_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         axis_x_ff <= {AXIS_NIL, AXIS_NIL, AXIS_ONE};
         axis_y_ff <= {AXIS_NIL, AXIS_ONE, AXIS_NIL};
         axis_z_ff <= {AXIS_ONE, AXIS_NIL, AXIS_NIL};
         half_ff   <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CENTER:      center_ff <= csr_wdata[CTR_BITS-1:0];
            CSR_AXIS_X:      axis_x_ff <= csr_wdata[AXV_BITS-1:0];
            CSR_AXIS_Y:      axis_y_ff <= csr_wdata[AXV_BITS-1:0];
            CSR_AXIS_Z:      axis_z_ff <= csr_wdata[AXV_BITS-1:0];
            CSR_HALF_EXTENT: half_ff   <= csr_wdata[CTR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Stage handshake: a stage loads when it is empty or its item moves on
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic ready1, ready2, ready3, ready4;
   stage_ctrl_type lane_ctrl;

   assign ready4    = !valid4_ff || rsp_ready;
   assign ready3    = !valid3_ff || ready4;
   assign ready2    = !valid2_ff || ready3;
   assign ready1    = !valid1_ff || ready2;
   assign req_ready = ready1;

   assign lane_ctrl.prod_load = ready2;
   assign lane_ctrl.dot_load  = ready3;
   assign lane_ctrl.cmp_load  = ready4;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= req_valid;
         if (ready2) valid2_ff <= valid1_ff;
         if (ready3) valid3_ff <= valid2_ff;
         if (ready4) valid4_ff <= valid3_ff;
      end
   end

   // Stage 1: point minus centre, one bit wider
   logic [COORD_BITS-1:0]  point [3];
   logic [3*DIFF_BITS-1:0] diff_in;
   logic [3*DIFF_BITS-1:0] diff_ff;

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i*DIFF_BITS +: DIFF_BITS] =
              DIFF_BITS'($signed(point[i]))
            - DIFF_BITS'($signed(center_ff[i*COORD_BITS +: COORD_BITS]));
      end
   end

   // Index and last marker ride along with the item
   logic [INDEX_BITS-1:0] idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic                  last1_ff, last2_ff, last3_ff, last4_ff;

   always_ff @(posedge clock) begin
      if (ready1) begin
         diff_ff  <= diff_in;
         idx1_ff  <= req_point_index;
         last1_ff <= req_last_point;
      end
      if (ready2) begin
         idx2_ff  <= idx1_ff;
         last2_ff <= last1_ff;
      end
      if (ready3) begin
         idx3_ff  <= idx2_ff;
         last3_ff <= last2_ff;
      end
      if (ready4) begin
         idx4_ff  <= idx3_ff;
         last4_ff <= last3_ff;
      end
   end

   // Stages 2 to 4: one projection lane per box axis
   logic [AXV_BITS-1:0] axis_sel [3];
   logic [2:0]          lane_inside;

   assign axis_sel[0] = axis_x_ff;
   assign axis_sel[1] = axis_y_ff;
   assign axis_sel[2] = axis_z_ff;

   for (genvar k = 0; k < 3; k++) begin : g_lane
      obpc_axis_lane #(
         .COORD_BITS     (COORD_BITS),
         .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
      ) u_lane (
         .clock       (clock),
         .ctrl        (lane_ctrl),
         .diff        (diff_ff),
         .axis        (axis_sel[k]),
         .half_extent (half_ff[k*COORD_BITS +: COORD_BITS]),
         .in_box      (lane_inside[k])
      );
   end

   // Result
   assign rsp_valid        = valid4_ff;
   assign rsp_result_index = idx4_ff;
   assign rsp_inside_res   = &lane_inside;
   assign rsp_result_last  = last4_ff;

endmodule

@@ verif/oriented_box_point_crop_tb.sv @@
// Self-checking testbench for the oriented box point crop: directed boxes, then random boxes.
`timescale 1ns / 1ps

module oriented_box_point_crop_tb;
   import obpc_pkg::*;

   localparam int COORD_W       = COORD_BITS_DEF;
   localparam int FRAC_W        = AXIS_FRAC_BITS_DEF;
   localparam int AXIS_W        = FRAC_W + 2;
   localparam int INDEX_W       = INDEX_BITS_DEF;
   localparam int CSR_W         = (3*COORD_W > 3*AXIS_W) ? 3*COORD_W : 3*AXIS_W;
   localparam int PIPE_DEPTH    = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_POINTS  = 150;
   localparam int UNIT_AXIS     = 1 << FRAC_W;

   // One expected crop decision
   typedef struct {
      logic [INDEX_W-1:0] index;
      logic               in_box;
      logic               is_last;
   } crop_result_type;

   // Tracks the box registers and the decisions still owed by the block
   class crop_scoreboard_type;
      logic [3*COORD_W-1:0] center;
      logic [3*AXIS_W-1:0]  axis [3];
      logic [3*COORD_W-1:0] half;
      crop_result_type      expected_crops[$];
      int                   errors;
      int                   checked;
      int                   inside_seen;

      function new();
         center = '0;
         half   = '0;
         for (int k = 0; k < 3; k++) begin
            axis[k] = '0;
            axis[k][k*AXIS_W + FRAC_W] = 1'b1;
         end
         errors      = 0;
         checked     = 0;
         inside_seen = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_CENTER:      center  = data[3*COORD_W-1:0];
            CSR_AXIS_X:      axis[0] = data[3*AXIS_W-1:0];
            CSR_AXIS_Y:      axis[1] = data[3*AXIS_W-1:0];
            CSR_AXIS_Z:      axis[2] = data[3*AXIS_W-1:0];
            CSR_HALF_EXTENT: half    = data[3*COORD_W-1:0];
            default: ;
         endcase
      endfunction

      // Exact projection test against every axis, inclusive bound
      function bit is_inside(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                             logic signed [COORD_W-1:0] pz);
         longint d [3];
         longint dot;
         longint lim;
         bit     in_box;
         d[0] = longint'(px) - longint'($signed(center[0 +: COORD_W]));
         d[1] = longint'(py) - longint'($signed(center[COORD_W +: COORD_W]));
         d[2] = longint'(pz) - longint'($signed(center[2*COORD_W +: COORD_W]));
         in_box = 1'b1;
         for (int k = 0; k < 3; k++) begin
            dot = 0;
            for (int i = 0; i < 3; i++)
               dot += d[i] * longint'($signed(axis[k][i*AXIS_W +: AXIS_W]));
            lim = longint'(half[k*COORD_W +: COORD_W]) <<< FRAC_W;
            if (dot < 0)
               dot = -dot;
            if (dot > lim)
               in_box = 1'b0;
         end
         return in_box;
      endfunction

      function void note_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                               logic signed [COORD_W-1:0] pz, logic [INDEX_W-1:0] idx,
                               logic is_last);
         crop_result_type r;
         r.index   = idx;
         r.in_box  = is_inside(px, py, pz);
         r.is_last = is_last;
         expected_crops = {expected_crops, r};
      endfunction

      function void check_result(logic [INDEX_W-1:0] idx, logic in_box, logic is_last);
         crop_result_type r;
         if (expected_crops.size() == 0) begin
            $display("%0t: result with index %h arrived with no point pending", $time, idx);
            errors++;
            return;
         end
         r = expected_crops.pop_front();
         checked++;
         if (r.in_box)
            inside_seen++;
         if (idx !== r.index) begin
            $display("%0t: result_index expected %h actual %h", $time, r.index, idx);
            errors++;
         end
         if (in_box !== r.in_box) begin
            $display("%0t: inside_res for index %h expected %b actual %b",
                     $time, r.index, r.in_box, in_box);
            errors++;
         end
         if (is_last !== r.is_last) begin
            $display("%0t: result_last for index %h expected %b actual %b",
                     $time, r.index, r.is_last, is_last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_crops.size();
      endfunction
   endclass

   // Block ports
   logic                         clock           = 1'b0;
   logic                         reset           = 1'b1;
   logic                         req_valid       = 1'b0;
   logic                         req_ready;
   logic signed [COORD_W-1:0]    req_point_x     = '0;
   logic signed [COORD_W-1:0]    req_point_y     = '0;
   logic signed [COORD_W-1:0]    req_point_z     = '0;
   logic        [INDEX_W-1:0]    req_point_index = '0;
   logic                         req_last_point  = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready       = 1'b0;
   logic        [INDEX_W-1:0]    rsp_result_index;
   logic                         rsp_inside_res;
   logic                         rsp_result_last;
   logic                         csr_write_en    = 1'b0;
   logic [CSR_INDEX_BITS-1:0]    csr_index       = '0;
   logic [CSR_W-1:0]             csr_wdata       = '0;

   // Run control
   crop_scoreboard_type sb;
   logic           gaps_on      = 1'b0;
   logic           hold_request = 1'b0;
   int             hold_left    = 0;
   int             input_stalls = 0;
   int             phases       = 0;
   int             box_center [3];
   int             box_axis [3][3];
   int             box_half [3];

   always #2 clock = ~clock;

   oriented_box_point_crop u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .req_point_index  (req_point_index),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_index (rsp_result_index),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_result_last  (rsp_result_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Result side: check accepted items, random stalls, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_result_index, rsp_inside_res, rsp_result_last);
         if (req_valid && !req_ready)
            input_stalls++;
         if (hold_request)
            hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(gaps_on && $urandom_range(0, 99) < 20);
         end
      end
   end

   function automatic int rand_signed(int bits);
      logic [31:0] r;
      r = $urandom;
      return int'(r << (32 - bits)) >>> (32 - bits);
   endfunction

   function automatic logic [3*COORD_W-1:0] pack_coords(int a, int b, int c);
      logic [COORD_W-1:0] pa, pb, pc;
      pa = COORD_W'(a);
      pb = COORD_W'(b);
      pc = COORD_W'(c);
      return {pc, pb, pa};
   endfunction

   function automatic logic [3*AXIS_W-1:0] pack_axis(int a, int b, int c);
      logic [AXIS_W-1:0] pa, pb, pc;
      pa = AXIS_W'(a);
      pb = AXIS_W'(b);
      pc = AXIS_W'(c);
      return {pc, pb, pa};
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Load the whole box; axis writes carry junk above the register width
   task automatic apply_box(input bit junk_writes);
      logic [CSR_W-1:0]          upper;
      logic [CSR_INDEX_BITS-1:0] bad_idx;
      write_reg(CSR_CENTER, pack_coords(box_center[0], box_center[1], box_center[2]));
      for (int k = 0; k < 3; k++) begin
         upper = CSR_W'({$urandom, $urandom});
         write_reg(csr_code_type'(CSR_AXIS_X + k),
                   (upper << 3*AXIS_W) |
                   CSR_W'(pack_axis(box_axis[k][0], box_axis[k][1], box_axis[k][2])));
      end
      write_reg(CSR_HALF_EXTENT, pack_coords(box_half[0], box_half[1], box_half[2]));
      if (junk_writes) begin
         repeat (2) begin
            bad_idx = CSR_INDEX_BITS'($urandom_range(CSR_HALF_EXTENT + 1,
                                                     (1 << CSR_INDEX_BITS) - 1));
            write_reg(bad_idx, CSR_W'({$urandom, $urandom}));
         end
      end
      csr_write_en <= 1'b0;
   endtask

   task automatic set_identity_axes();
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++)
            box_axis[k][i] = (k == i) ? UNIT_AXIS : 0;
   endtask

   task automatic send_point(input int x, input int y, input int z,
                             input logic [INDEX_W-1:0] idx, input logic is_last);
      logic signed [COORD_W-1:0] px, py, pz;
      px = COORD_W'(x);
      py = COORD_W'(y);
      pz = COORD_W'(z);
      req_valid       <= 1'b1;
      req_point_x     <= px;
      req_point_y     <= py;
      req_point_z     <= pz;
      req_point_index <= idx;
      req_last_point  <= is_last;
      do @(posedge clock); while (!req_ready);
      sb.note_point(px, py, pz, idx, is_last);
   endtask

   // Let the pipeline drain before touching the registers again
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (2*PIPE_DEPTH) @(posedge clock);
      phases++;
   endtask

   // Random box: centre, axis style and extents each drawn per phase
   task automatic pick_box();
      int axis_mode;
      bit full_center;
      full_center = ($urandom_range(0, 2) == 0);
      axis_mode   = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
         box_center[k] = full_center ? rand_signed(COORD_W) : rand_signed(15);
         case ($urandom_range(0, 9))
            0:       box_half[k] = 0;
            1:       box_half[k] = $urandom_range(0, (1 << COORD_W) - 1);
            default: box_half[k] = $urandom_range(1, 5000);
         endcase
         for (int i = 0; i < 3; i++) begin
            case (axis_mode)
               0:       box_axis[k][i] = (k != i) ? 0 :
                                         ($urandom_range(0, 1) ? UNIT_AXIS : -UNIT_AXIS);
               1:       box_axis[k][i] = int'($urandom_range(0, 2*UNIT_AXIS)) - UNIT_AXIS;
               default: box_axis[k][i] = rand_signed(AXIS_W);
            endcase
         end
      end
   endtask

   // Points mostly near the centre, on and just past the faces, some anywhere
   task automatic gen_point(output int pt [3]);
      int h;
      int off;
      bit anywhere;
      anywhere = ($urandom_range(0, 99) < 15);
      for (int k = 0; k < 3; k++) begin
         h = box_half[k];
         case ($urandom_range(0, 15))
            0, 1, 2: off = h;
            3, 4:    off = h + 1;
            12, 13, 14, 15:
                     off = int'($urandom_range(0, 4*h + 100)) - (2*h + 50);
            default: off = int'($urandom_range(0, 2*h)) - h;
         endcase
         if ($urandom_range(0, 1) && off != 0 && $urandom_range(0, 3) != 0)
            off = -off;
         pt[k] = anywhere ? rand_signed(COORD_W) : box_center[k] + off;
      end
   endtask

   // Main sequence
   initial begin
      int pt [3];
      bit with_gaps;
      sb = new();
      box_center = '{0, 0, 0};
      box_half   = '{0, 0, 0};
      set_identity_axes();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset state: zero extent, so only the exact centre is inside
      send_point(0, 0, 0, '0, 1'b0);
      send_point(1, 0, 0, {INDEX_W{1'b1}}, 1'b1);
      send_point(0, 0, -1, 20'h5a5a5, 1'b0);
      finish_phase();

      // Largest extents with the centre at the coordinate extremes
      box_center = '{524287, -524288, 0};
      box_half   = '{1048575, 1048575, 1048575};
      apply_box(1'b0);
      send_point(-524288, 524287, 0, 20'h00001, 1'b0);
      send_point(524287, -524288, 524287, 20'h80000, 1'b1);
      send_point(-524288, -524288, -524288, {INDEX_W{1'b1}}, 1'b0);
      finish_phase();

      // Faces of a small box: on the face is inside, one past is outside
      box_center = '{10, -20, 30};
      box_half   = '{100, 200, 300};
      apply_box(1'b1);
      send_point(110, -220, 330, 20'h00010, 1'b0);
      send_point(-90, 180, -270, 20'h00011, 1'b0);
      send_point(111, -20, 30, 20'h00012, 1'b0);
      send_point(10, 181, 30, 20'h00013, 1'b0);
      send_point(10, -20, 331, 20'h00014, 1'b0);
      send_point(-91, -20, 30, 20'h00015, 1'b1);
      finish_phase();

      // Extreme axis components, zero extents on the first and third axes
      box_center  = '{-524288, 524287, -524288};
      box_half    = '{0, 1048575, 0};
      box_axis[0] = '{-32768, 32767, -32768};
      box_axis[1] = '{32767, -32768, 32767};
      box_axis[2] = '{-32768, -32768, -32768};
      apply_box(1'b1);
      send_point(-524288, 524287, -524288, 20'h00020, 1'b0);
      send_point(524287, -524288, 524287, 20'h00021, 1'b1);
      send_point(-524287, 524287, -524288, 20'h00022, 1'b0);
      finish_phase();

      // Degenerate axes: nonzero offset with zero projection counts as inside
      box_center = '{0, 0, 0};
      box_half   = '{0, 0, 0};
      for (int k = 0; k < 3; k++)
         box_axis[k] = '{UNIT_AXIS, -UNIT_AXIS, 0};
      apply_box(1'b0);
      send_point(5, 5, 7, 20'h00030, 1'b0);
      send_point(5, 4, 0, 20'h00031, 1'b1);
      finish_phase();

      // Random boxes; the first runs without idling, two see a long result hold-off
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         with_gaps = (p != 0);
         gaps_on  <= with_gaps;
         pick_box();
         apply_box(p % 2 == 1);
         if (p == 2 || p == 5) begin
            hold_request <= 1'b1;
            @(posedge clock);
            hold_request <= 1'b0;
         end
         for (int n = 0; n < PHASE_POINTS; n++) begin
            if (with_gaps && $urandom_range(0, 99) < 20) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end
            gen_point(pt);
            send_point(pt[0], pt[1], pt[2], INDEX_W'($urandom),
                       (n == PHASE_POINTS - 1) || ($urandom_range(0, 15) == 0));
         end
         finish_phase();
      end

      $display("Checked %0d points against %0d box settings, %0d of them inside.",
               sb.checked, phases, sb.inside_seen);
      $display("Input side was held back by a full pipeline for %0d cycles.", input_stalls);
      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
